FILE: sv/tmt_pkg.sv
// Package for the tile mismatch tracker: controller command/status types and opcodes.
// Used by tmt_ctrl, tmt_dp and tile_mismatch_tracker.
`timescale 1ns / 1ps
`default_nettype none
package tmt_pkg;
	localparam logic [1:0] OP_REPORT    = 2'd0;
	localparam logic [1:0] OP_RESET_CH  = 2'd1;
	localparam logic [1:0] OP_RESET_ALL = 2'd2;

	localparam logic [3:0] RUN_MAX = 4'd15;

	// controller to datapath
	typedef struct packed {
		logic latch;    // capture the input beat
		logic rd;       // read bitmaps at current address
		logic upd;      // apply the compare result to the current tile
		logic mark;     // mark the current backfill tile
		logic clr;      // clear at the clear address, advance it
		logic clr_init; // load clear address
		logic load_out; // build the result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_clear;  // beat needs a clear sweep
		logic is_report; // beat compares a report
		logic do_mark;   // threshold reached, backfill needed
		logic mark_last; // backfill pointer at current tile
		logic clr_last;  // clear sweep at last entry
	} sts_t;
endpackage
`default_nettype wire

FILE: sv/tile_mismatch_tracker.sv
// Tile mismatch tracker top level: stream in/out, APB configuration, controller and datapath.
// A compared report reads both bitmaps, updates the tile and may backfill up to 15 tiles; other
// beats go straight to the result; a channel reset sweeps that channel's entries and a reset-all
// sweeps every channel (one bit pair cleared a cycle); the result waits while the last is untaken.
// One beat in flight; s_tready returns the cycle after the result is loaded.
// arst_n clears counters and run state, sets control to its defaults, then sweeps both bitmaps with s_tready low.
`timescale 1ns / 1ps
`default_nettype none
module tile_mismatch_tracker #(
	parameter int CHANNELS  = 8,
	parameter int MAX_TILES = 4096,
	parameter int HASH_BITS = 48
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// opcode[1:0], channel[5:2], tile[17:6], reported_hash[65:18], baseline_valid[66],
	// baseline_hash[130:67]
	input  wire logic [135:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// channel_ok[0], compared[1], matched[2], tiles_checked[15:3],
	// tiles_mismatched[28:16], stale[29]
	output logic [31:0]       m_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	tmt_pkg::cmd_t cmd;
	tmt_pkg::sts_t sts;
	logic [3:0] hyst_q;
	logic [6:0] stale_q;
	logic [31:0] res;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyst_q  <= 4'd3;
			stale_q <= 7'd10;
		end else if (psel && penable && pwrite) begin
			if (paddr == 3'd0) hyst_q <= pwdata[3:0];
			else if (paddr == 3'd4) stale_q <= pwdata[6:0];
		end
	end
	assign prdata = (paddr == 3'd0) ? {28'd0, hyst_q} :
		(paddr == 3'd4) ? {25'd0, stale_q} : 32'd0;

	tmt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.out_busy(m_tvalid && !m_tready), .sts(sts), .cmd(cmd)
	);

	tmt_dp #(.CHANNELS(CHANNELS), .MAX_TILES(MAX_TILES), .HASH_BITS(HASH_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.opcode(s_tdata[1:0]), .channel(s_tdata[5:2]), .tile(s_tdata[17:6]),
		.reported_hash(s_tdata[65:18]), .baseline_valid(s_tdata[66]),
		.baseline_hash(s_tdata[130:67]), .hysteresis_tiles(hyst_q),
		.stale_percent(stale_q), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (cmd.load_out) m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end
	assign m_tdata = res;

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(m_tvalid && !m_tready)) else $error("result overwritten");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clr || cmd.mark) |-> !s_tready) else $error("input taken mid-work");
	a_ok_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] || m_tdata[29:1] == 29'd0)) else $error("fields on bad channel");
endmodule
`default_nettype wire

FILE: sv/tmt_ctrl.sv
// Controller state machine of the tile mismatch tracker.
// Depends on tmt_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module tmt_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic         out_busy,
	input  wire tmt_pkg::sts_t sts,
	output tmt_pkg::cmd_t     cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_UPD  = 4'd3;
	localparam logic [3:0] S_MRD  = 4'd4;
	localparam logic [3:0] S_MARK = 4'd5;
	localparam logic [3:0] S_CLR  = 4'd6;
	localparam logic [3:0] S_OUT  = 4'd7;
	localparam logic [3:0] S_BOOT = 4'd8;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_BOOT;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			// sweep both bitmaps once after reset
			S_BOOT: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.is_clear) begin
					cmd.clr_init = 1'b1;
					state_d = S_CLR;
				end else if (sts.is_report) begin
					cmd.rd = 1'b1;
					state_d = S_RD;
				end else state_d = S_OUT;
			end
			S_RD: state_d = S_UPD;
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = sts.do_mark ? S_MRD : S_OUT;
			end
			S_MRD: begin
				cmd.rd = 1'b1;
				state_d = S_MARK;
			end
			S_MARK: begin
				cmd.mark = 1'b1;
				state_d = sts.mark_last ? S_OUT : S_MRD;
			end
			S_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_busy) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

FILE: sv/tmt_dp.sv
// Datapath of the tile mismatch tracker: bitmaps, per-channel counters, result build.
// Depends on tmt_pkg; driven by tmt_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
module tmt_dp #(
	parameter int CHANNELS  = 8,
	parameter int MAX_TILES = 4096,
	parameter int HASH_BITS = 48
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tmt_pkg::cmd_t cmd,
	output tmt_pkg::sts_t      sts,
	input  wire logic [1:0]    opcode,
	input  wire logic [3:0]    channel,
	input  wire logic [11:0]   tile,
	input  wire logic [47:0]   reported_hash,
	input  wire logic          baseline_valid,
	input  wire logic [63:0]   baseline_hash,
	input  wire logic [3:0]    hysteresis_tiles,
	input  wire logic [6:0]    stale_percent,
	output logic [31:0]        res
);
	localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	// the tile field is 12 bits, so a larger tile count never needs more row bits
	localparam int TW    = (MAX_TILES > 4096) ? 12 : $clog2(MAX_TILES);
	localparam int AW    = CHW + TW;
	localparam int DEPTH = CHANNELS * (1 << TW);
	localparam int HB    = (HASH_BITS > 48) ? 48 : HASH_BITS;
	localparam int HBB   = (HASH_BITS > 64) ? 64 : HASH_BITS;

	logic chk_mem [DEPTH];
	logic mis_mem [DEPTH];

	logic [1:0]    op_q;
	logic          ok_q;
	logic [CHW-1:0] ch_q;
	logic [11:0]   tile_q;
	logic          bv_q, match_q, inrange_q;
	logic [TW-1:0] mptr_q;
	logic [AW-1:0] caddr_q;
	logic          call_q;
	logic          chk_rd_q, mis_rd_q;
	logic          domark_q;

	logic [12:0] ccnt_q [CHANNELS];
	logic [12:0] mcnt_q [CHANNELS];
	logic [3:0]  run_q  [CHANNELS];
	logic [11:0] last_q [CHANNELS];
	logic        ract_q [CHANNELS];

	logic [4:0] chn_ext;
	assign chn_ext = {1'b0, channel};

	logic [3:0] hyst;
	assign hyst = (hysteresis_tiles == 4'd0) ? 4'd1 : hysteresis_tiles;

	// run update for current channel
	logic        adj;
	logic [3:0]  run_new;
	logic [12:0] back_first;
	assign adj = ract_q[ch_q] && ({1'b0, tile_q} == {1'b0, last_q[ch_q]} + 13'd1);
	assign run_new = adj ? ((run_q[ch_q] < tmt_pkg::RUN_MAX) ? run_q[ch_q] + 4'd1
		: tmt_pkg::RUN_MAX) : 4'd1;
	assign back_first = ({1'b0, tile_q} >= {9'd0, hyst - 4'd1})
		? {1'b0, tile_q} - {9'd0, hyst - 4'd1} : 13'd0;

	logic [AW-1:0] raddr;
	assign raddr = {ch_q, (cmd.rd && domark_q) ? mptr_q : tile_q[TW-1:0]};

	logic [AW-1:0] last_caddr;
	assign last_caddr = call_q ? AW'(DEPTH - 1) : {ch_q, {TW{1'b1}}};

	logic stale_now;
	assign stale_now = ccnt_q[ch_q] != 13'd0 &&
		({7'd0, mcnt_q[ch_q]} * 20'd100) >
		({7'd0, ccnt_q[ch_q]} * {13'd0, stale_percent});

	assign sts.is_clear  = ok_q ? (op_q == tmt_pkg::OP_RESET_ALL || op_q == tmt_pkg::OP_RESET_CH)
		: (op_q == tmt_pkg::OP_RESET_ALL);
	assign sts.is_report = ok_q && op_q == tmt_pkg::OP_REPORT && bv_q && inrange_q;
	assign sts.do_mark   = !match_q && run_new >= hyst;
	assign sts.mark_last = mptr_q == tile_q[TW-1:0];
	assign sts.clr_last  = caddr_q == last_caddr;

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			chk_rd_q <= chk_mem[raddr];
			mis_rd_q <= mis_mem[raddr];
		end
		if (cmd.upd) begin
			chk_mem[{ch_q, tile_q[TW-1:0]}] <= 1'b1;
			if (match_q) mis_mem[{ch_q, tile_q[TW-1:0]}] <= 1'b0;
		end
		if (cmd.mark) mis_mem[{ch_q, mptr_q}] <= 1'b1;
		if (cmd.clr) begin
			chk_mem[caddr_q] <= 1'b0;
			mis_mem[caddr_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				ccnt_q[i] <= '0;
				mcnt_q[i] <= '0;
				run_q[i]  <= '0;
				last_q[i] <= '0;
				ract_q[i] <= 1'b0;
			end
			domark_q <= 1'b0;
			res      <= '0;
			// start the power-up sweep over every channel
			call_q   <= 1'b1;
			caddr_q  <= '0;
		end else begin
			if (cmd.latch) begin
				domark_q <= 1'b0;
				call_q   <= opcode == tmt_pkg::OP_RESET_ALL;
			end
			if (cmd.upd) begin
				if (!chk_rd_q) ccnt_q[ch_q] <= ccnt_q[ch_q] + 13'd1;
				if (match_q) begin
					run_q[ch_q]  <= '0;
					ract_q[ch_q] <= 1'b0;
					if (mis_rd_q) mcnt_q[ch_q] <= mcnt_q[ch_q] - 13'd1;
				end else begin
					run_q[ch_q]  <= run_new;
					last_q[ch_q] <= tile_q;
					ract_q[ch_q] <= 1'b1;
					domark_q     <= sts.do_mark;
				end
			end
			if (cmd.mark && !mis_rd_q) mcnt_q[ch_q] <= mcnt_q[ch_q] + 13'd1;
			if (cmd.clr_init) begin
				for (int i = 0; i < CHANNELS; i++) begin
					if (call_q || CHW'(i) == ch_q) begin
						ccnt_q[i] <= '0;
						mcnt_q[i] <= '0;
						run_q[i]  <= '0;
						last_q[i] <= '0;
						ract_q[i] <= 1'b0;
					end
				end
			end
			if (cmd.clr_init) caddr_q <= call_q ? '0 : {ch_q, {TW{1'b0}}};
			if (cmd.clr) caddr_q <= caddr_q + AW'(1);
			if (cmd.load_out) begin
				res <= ok_q ? {2'b00, stale_now, mcnt_q[ch_q], ccnt_q[ch_q],
					sts.is_report && match_q, sts.is_report, 1'b1} : 32'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q      <= opcode;
			ok_q      <= channel != 4'd0 && {28'd0, channel} <= 32'(CHANNELS);
			ch_q      <= CHW'(chn_ext - 5'd1);
			tile_q    <= tile;
			bv_q      <= baseline_valid;
			inrange_q <= {20'd0, tile} < 32'(MAX_TILES);
			match_q   <= (baseline_hash[HBB-1:0] == {{(HBB-HB){1'b0}}, reported_hash[HB-1:0]});
		end
		if (cmd.upd) mptr_q <= back_first[TW-1:0];
		if (cmd.mark) mptr_q <= mptr_q + TW'(1);
	end
endmodule
`default_nettype wire

FILE: bench/tile_mismatch_tracker_test.sv
// Self-checking bench for tile_mismatch_tracker: stream driver, result monitor, APB writes.
// Predicts every result from a behavioral copy of the per-channel bitmaps; needs tmt_pkg.
`timescale 1ns / 1ps
module tile_mismatch_tracker_test;
	localparam logic [1:0] OP_QUERY = 2'd3;
	localparam int REG_HYST = 0;
	localparam int REG_STALE = 1;
	localparam int NCH = 8;
	localparam int NTILES = 4096;
	localparam int STALL_LIMIT = 150000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [1:0]  op;
		logic [3:0]  ch;
		logic [11:0] tile;
		logic [47:0] rep;
		logic        bv;
		logic [63:0] base;
	} report_t;

	typedef struct {
		logic        ok;
		logic        cmp;
		logic        mat;
		logic [12:0] chk;
		logic [12:0] mis;
		logic        stale;
	} status_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [135:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [31:0] m_tdata;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	tile_mismatch_tracker dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// tracker state shadow
	bit chk_map[NCH][NTILES];
	bit mis_map[NCH][NTILES];
	int chk_cnt[NCH], mis_cnt[NCH], run_len[NCH], last_tile[NCH];
	bit run_on[NCH];
	int hyst_reg = 3, pct_reg = 10;

	report_t pend_q[$];
	status_t status_q[$];
	report_t cur_beat;
	int errors = 0;
	logic s_took = 0, m_took = 0;
	int s_gap = 0, m_wait = 0, quiet_left = 0, idle_cycles = 0;

	task automatic clear_channel(input int c);
		for (int t = 0; t < NTILES; t++) begin
			chk_map[c][t] = 0;
			mis_map[c][t] = 0;
		end
		chk_cnt[c] = 0;
		mis_cnt[c] = 0;
		run_len[c] = 0;
		last_tile[c] = 0;
		run_on[c] = 0;
	endtask

	task automatic track_report(input report_t b, output status_t r);
		int c, t, hy, first;
		r = '{default: '0};
		if (b.op == tmt_pkg::OP_RESET_ALL)
			for (int i = 0; i < NCH; i++) clear_channel(i);
		if (b.ch < 1 || b.ch > NCH) return;
		c = b.ch - 1;
		t = b.tile;
		if (b.op == tmt_pkg::OP_RESET_CH) begin
			clear_channel(c);
		end else if (b.op == tmt_pkg::OP_REPORT && b.bv) begin
			r.cmp = 1;
			if (!chk_map[c][t]) begin
				chk_map[c][t] = 1;
				chk_cnt[c]++;
			end
			r.mat = (b.base[47:0] == b.rep);
			if (r.mat) begin
				run_len[c] = 0;
				run_on[c] = 0;
				if (mis_map[c][t]) begin
					mis_map[c][t] = 0;
					mis_cnt[c]--;
				end
			end else begin
				hy = (hyst_reg == 0) ? 1 : hyst_reg;
				if (run_on[c] && t == last_tile[c] + 1)
					run_len[c] = (run_len[c] < 15) ? run_len[c] + 1 : 15;
				else
					run_len[c] = 1;
				last_tile[c] = t;
				run_on[c] = 1;
				if (run_len[c] >= hy) begin
					first = (t >= hy - 1) ? t - (hy - 1) : 0;
					for (int k = first; k <= t; k++)
						if (!mis_map[c][k]) begin
							mis_map[c][k] = 1;
							mis_cnt[c]++;
						end
				end
			end
		end
		r.ok = 1;
		r.chk = chk_cnt[c][12:0];
		r.mis = mis_cnt[c][12:0];
		r.stale = (chk_cnt[c] != 0) &&
			(longint'(mis_cnt[c]) * 100 > longint'(chk_cnt[c]) * pct_reg);
	endtask

	function automatic report_t mk(input logic [1:0] op, input int ch, input int tile,
		input logic [47:0] rep, input logic bv, input logic [63:0] base);
		report_t b;
		b.op = op;
		b.ch = 4'(ch);
		b.tile = 12'(tile);
		b.rep = rep;
		b.bv = bv;
		b.base = base;
		return b;
	endfunction

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	task automatic check_field(input string name, input longint exp, input longint act);
		if (exp != act) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			errors++;
		end
	endtask

	// monitor: predict on input beats, compare output beats, watchdog
	always @(posedge clk) begin
		status_t e;
		s_took <= s_tvalid && s_tready;
		m_took <= m_tvalid && m_tready;
		if (s_tvalid && s_tready) begin
			track_report(cur_beat, e);
			status_q.push_back(e);
		end
		if (m_tvalid && m_tready) begin
			if (status_q.size() == 0) begin
				$error("result beat with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				e = status_q.pop_front();
				check_field("channel_ok", e.ok, m_tdata[0]);
				check_field("compared", e.cmp, m_tdata[1]);
				check_field("matched", e.mat, m_tdata[2]);
				check_field("tiles_checked", e.chk, m_tdata[15:3]);
				check_field("tiles_mismatched", e.mis, m_tdata[28:16]);
				check_field("stale", e.stale, m_tdata[29]);
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else if (idle_cycles + 1 >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// driver: one beat at a time from pend_q, random gaps with quiet stretches
	always @(negedge clk) begin
		logic nv;
		nv = s_tvalid;
		if (arst_n && (!s_tvalid || s_took)) begin
			if (s_gap > 0) begin
				s_gap--;
				nv = 0;
			end else if (pend_q.size() != 0) begin
				cur_beat = pend_q.pop_front();
				s_tdata <= {5'b0, cur_beat.base, cur_beat.bv, cur_beat.rep,
					cur_beat.tile, cur_beat.ch, cur_beat.op};
				nv = 1;
				if (quiet_left > 0) begin
					quiet_left--;
					s_gap = 0;
				end else begin
					s_gap = $urandom_range(0, 19);
					if ($urandom_range(0, 49) == 0) quiet_left = $urandom_range(10, 40);
				end
			end else
				nv = 0;
		end
		s_tvalid <= nv;
		if (m_took) m_wait = (quiet_left > 0) ? 0 : $urandom_range(0, 19);
		if (m_wait > 0) begin
			m_wait--;
			m_tready <= 0;
		end else
			m_tready <= arst_n;
	end

	task automatic apb_write(input int idx, input int value);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= 3'(4 * idx);
		pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (idx == REG_HYST) hyst_reg = value & 4'hF;
		else pct_reg = value & 7'h7F;
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pend_q.size() != 0 || s_tvalid || status_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly adjacent mismatch runs on one channel, with matches, gaps and noise
	task automatic queue_random(input int n);
		int k, sel, ch, t, len;
		logic [47:0] rep;
		k = 0;
		while (k < n) begin
			sel = $urandom_range(0, 99);
			if (sel < 72) begin
				ch = $urandom_range(1, NCH);
				case ($urandom_range(0, 9))
					0: t = $urandom_range(0, 3);
					1: t = $urandom_range(NTILES - 12, NTILES - 1);
					default: t = $urandom_range(0, 255);
				endcase
				len = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 20)
					: $urandom_range(1, 8);
				for (int i = 0; i < len && t < NTILES; i++) begin
					rep = rand48();
					case ($urandom_range(0, 19))
						0: pend_q.push_back(mk(tmt_pkg::OP_REPORT, ch, t, rep, 1'b0,
							{$urandom(), $urandom()}));
						1, 2: pend_q.push_back(mk(tmt_pkg::OP_REPORT, ch, t, rep, 1'b1,
							{16'($urandom()), rep}));
						default: pend_q.push_back(mk(tmt_pkg::OP_REPORT, ch, t, rep, 1'b1,
							{16'($urandom()), rep ^ (48'd1 << $urandom_range(0, 47))}));
					endcase
					k++;
					t += ($urandom_range(0, 15) == 0) ? 2 : 1;
				end
			end else begin
				sel = $urandom_range(0, 199);
				rep = rand48();
				pend_q.push_back(mk(sel == 0 ? tmt_pkg::OP_RESET_ALL :
					sel < 5 ? tmt_pkg::OP_RESET_CH :
					sel < 30 ? OP_QUERY : tmt_pkg::OP_REPORT, $urandom_range(0, 15),
					$urandom_range(0, NTILES - 1), rep, 1'($urandom_range(0, 1)),
					$urandom_range(0, 3) == 0 ? {16'($urandom()), rep}
						: {$urandom(), $urandom()}));
				k++;
			end
		end
	endtask

	initial begin
		int hy_set[6] = '{3, 1, 8, 0, 15, 2};
		int pc_set[6] = '{10, 0, 100, 50, 127, 33};
		for (int c = 0; c < NCH; c++) clear_channel(c);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// first beats land on the bitmaps as left by reset
		pend_q.push_back(mk(tmt_pkg::OP_REPORT, 1, 0, '0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
		pend_q.push_back(mk(tmt_pkg::OP_REPORT, 1, 1, '1, 1'b1, '0));
		pend_q.push_back(mk(tmt_pkg::OP_REPORT, 1, 2, 48'h1234, 1'b1, 64'h1235));
		pend_q.push_back(mk(tmt_pkg::OP_REPORT, 1, 1, 48'hABC, 1'b1, 64'hFFFF_0000_0000_0ABC));
		pend_q.push_back(mk(tmt_pkg::OP_REPORT, 1, 5, '1, 1'b0, '0));
		pend_q.push_back(mk(tmt_pkg::OP_REPORT, 2, 4093, '0, 1'b1, 64'h1));
		pend_q.push_back(mk(tmt_pkg::OP_REPORT, 2, 4094, '0, 1'b1, 64'h2));
		pend_q.push_back(mk(tmt_pkg::OP_REPORT, 2, 4095, '0, 1'b1, 64'h3));
		pend_q.push_back(mk(tmt_pkg::OP_REPORT, 8, 4095, '1, 1'b1, '1));
		pend_q.push_back(mk(tmt_pkg::OP_REPORT, 0, 7, '0, 1'b1, 64'h5));
		pend_q.push_back(mk(tmt_pkg::OP_REPORT, 9, 7, '0, 1'b1, 64'h5));
		pend_q.push_back(mk(tmt_pkg::OP_RESET_CH, 15, 0, '0, 1'b0, '0));
		pend_q.push_back(mk(OP_QUERY, 2, 4095, '1, 1'b1, '0));
		pend_q.push_back(mk(OP_QUERY, 0, 0, '0, 1'b0, '0));
		pend_q.push_back(mk(tmt_pkg::OP_RESET_CH, 0, 0, '0, 1'b0, '0));
		pend_q.push_back(mk(tmt_pkg::OP_RESET_CH, 2, 0, '0, 1'b0, '0));
		pend_q.push_back(mk(OP_QUERY, 2, 0, '0, 1'b0, '0));
		pend_q.push_back(mk(OP_QUERY, 1, 0, '0, 1'b0, '0));
		pend_q.push_back(mk(tmt_pkg::OP_RESET_ALL, 0, 0, '0, 1'b0, '0));
		pend_q.push_back(mk(OP_QUERY, 1, 0, '0, 1'b0, '0));
		drain();

		for (int p = 0; p < 6; p++) begin
			if (p > 0) begin
				apb_write(REG_HYST, hy_set[p]);
				apb_write(REG_STALE, pc_set[p]);
			end
			queue_random(190);
			drain();
		end

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
